/* src/kmp_pkg.sv */
// kmp matcher package: field widths, input kinds and parameter defaults
`default_nettype none
package kmp_pkg;

  localparam int unsigned KIND_W          = 2;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned MATCH_START_W   = 32;
  localparam int unsigned DEF_MAX_PATTERN = 64;
  localparam int unsigned DEF_POS_BITS    = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAT_FIRST = 2'd0,
    KIND_PAT_NEXT  = 2'd1,
    KIND_TXT_FIRST = 2'd2,
    KIND_TXT_NEXT  = 2'd3
  } kind_e;

endpackage
`default_nettype wire

/* src/kmp_in_if.sv */
// input request channel: kind and byte value
`default_nettype none
interface kmp_in_if;
  import kmp_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, output kind, output byte_value, input ready);
  modport sink (input valid, input kind, input byte_value, output ready);
endinterface
`default_nettype wire

/* src/kmp_out_if.sv */
// result request channel: match flag, start offset and overflow flag
`default_nettype none
interface kmp_out_if;
  import kmp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     match_found;
  logic [MATCH_START_W-1:0] match_start;
  logic                     pattern_overflow;

  modport source (output valid, output match_found, output match_start,
                  output pattern_overflow, input ready);
  modport sink (input valid, input match_found, input match_start,
                input pattern_overflow, output ready);
endinterface
`default_nettype wire

/* src/kmp_stream_matcher_core.sv */
// streaming kmp matcher: sequencer over pattern and failure memories
// a first pattern byte, a dropped one or one after an empty pattern is taken in idle; any other pattern byte
// and every text byte walk the failure links, a text byte also waits for output stalls; result registered
// each failure-link step is a registered memory read; input is not ready during the walk, one byte at a time
// reset: asynchronous, active low, clears lengths, position, flags and the output register
// memory contents are undefined after reset; words at or above the written length may be read but go unused
`default_nettype none
module kmp_stream_matcher_core #(
  parameter int unsigned MAX_PATTERN   = kmp_pkg::DEF_MAX_PATTERN,
  parameter int unsigned POSITION_BITS = kmp_pkg::DEF_POS_BITS
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  kmp_in_if.sink   in_i,
  kmp_out_if.source out_o
);
  import kmp_pkg::*;

  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned POS_W = POSITION_BITS;

  typedef enum logic {ST_IDLE, ST_WALK} state_e;

  state_e             state_q, state_d;
  logic               text_mode_q, text_mode_d;
  logic [IDX_W-1:0]   q_q, q_d;
  logic [BYTE_W-1:0]  c_q, c_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [IDX_W-1:0]   bp_q, bp_d;
  logic [LEN_W-1:0]   tml_q, tml_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               ovf_q, ovf_d;
  logic               out_valid_q, out_valid_d;
  logic               found_q, found_d;
  logic [MATCH_START_W-1:0] start_q, start_d;
  logic               out_ovf_q, out_ovf_d;

  logic               pat_we, fail_we, rd_en;
  logic [IDX_W-1:0]   pat_waddr, fail_waddr, rd_addr;
  logic [BYTE_W-1:0]  pat_wdata, pat_rdata;
  logic [IDX_W-1:0]   fail_wdata, fail_rdata;

  logic               hit, step, slot_free;
  logic [LEN_W-1:0]   qs, q0, fin;
  logic [POS_W-1:0]   start_full;

  kmp_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PATTERN)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_waddr),
    .wdata_i (pat_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (pat_rdata)
  );

  kmp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PATTERN)) u_fail_ram (
    .clk_i   (clk_i),
    .we_i    (fail_we),
    .waddr_i (fail_waddr),
    .wdata_i (fail_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr - IDX_W'(1)),
    .rdata_o (fail_rdata)
  );

  assign in_i.ready             = (state_q == ST_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.match_found      = found_q;
  assign out_o.match_start      = start_q;
  assign out_o.pattern_overflow = out_ovf_q;

  assign hit       = (pat_rdata == c_q);
  assign step      = (q_q != '0) && !hit && (len_q != '0);
  assign slot_free = !out_valid_q || out_o.ready;
  assign fin       = (len_q == '0) ? '0 : (LEN_W'(q_q) + LEN_W'(hit));
  assign start_full = pos_q - POS_W'(len_q) + POS_W'(1);

  always_comb begin
    state_d     = state_q;
    text_mode_d = text_mode_q;
    q_d         = q_q;
    c_d         = c_q;
    len_d       = len_q;
    bp_d        = bp_q;
    tml_d       = tml_q;
    pos_d       = pos_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_o.ready;
    found_d     = found_q;
    start_d     = start_q;
    out_ovf_d   = out_ovf_q;
    pat_we      = 1'b0;
    pat_waddr   = IDX_W'(len_q);
    pat_wdata   = in_i.byte_value;
    fail_we     = 1'b0;
    fail_waddr  = IDX_W'(len_q);
    fail_wdata  = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    qs          = '0;
    q0          = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          c_d = in_i.byte_value;
          unique case (in_i.kind)
            KIND_PAT_FIRST: begin
              pat_we     = 1'b1;
              pat_waddr  = '0;
              fail_we    = 1'b1;
              fail_waddr = '0;
              len_d      = LEN_W'(1);
              bp_d       = '0;
              ovf_d      = 1'b0;
              tml_d      = '0;
              pos_d      = '0;
            end
            KIND_PAT_NEXT: begin
              if (len_q >= LEN_W'(MAX_PATTERN)) begin
                ovf_d = 1'b1;
              end else if (len_q == '0) begin
                pat_we     = 1'b1;
                fail_we    = 1'b1;
                len_d      = LEN_W'(1);
                bp_d       = '0;
              end else begin
                pat_we      = 1'b1;
                rd_en       = 1'b1;
                rd_addr     = bp_q;
                q_d         = bp_q;
                text_mode_d = 1'b0;
                state_d     = ST_WALK;
              end
            end
            default: begin
              if (in_i.kind == KIND_TXT_FIRST) begin
                qs    = '0;
                pos_d = '0;
              end else begin
                qs    = tml_q;
              end
              if (qs > len_q) begin
                q0 = '0;
              end else if (qs == len_q) begin
                q0 = LEN_W'(bp_q);
              end else begin
                q0 = qs;
              end
              rd_en       = 1'b1;
              rd_addr     = IDX_W'(q0);
              q_d         = IDX_W'(q0);
              text_mode_d = 1'b1;
              state_d     = ST_WALK;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (step) begin
          rd_en   = 1'b1;
          rd_addr = fail_rdata;
          q_d     = fail_rdata;
        end else if (!text_mode_q) begin
          fail_we    = 1'b1;
          fail_wdata = IDX_W'(fin);
          bp_d       = IDX_W'(fin);
          len_d      = len_q + LEN_W'(1);
          state_d    = ST_IDLE;
        end else if (slot_free) begin
          tml_d       = fin;
          found_d     = (fin == len_q) && (len_q != '0);
          start_d     = ((fin == len_q) && (len_q != '0)) ?
                        MATCH_START_W'(start_full) : '0;
          out_ovf_d   = ovf_q;
          out_valid_d = 1'b1;
          pos_d       = pos_q + POS_W'(1);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      text_mode_q <= 1'b0;
      q_q         <= '0;
      c_q         <= '0;
      len_q       <= '0;
      bp_q        <= '0;
      tml_q       <= '0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      start_q     <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      text_mode_q <= text_mode_d;
      q_q         <= q_d;
      c_q         <= c_d;
      len_q       <= len_d;
      bp_q        <= bp_d;
      tml_q       <= tml_d;
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      start_q     <= start_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

endmodule
`default_nettype wire

/* src/kmp_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module kmp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* test/kmp_stream_matcher_core_tb.sv */
// testbench for the streaming kmp matcher: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module kmp_stream_matcher_core_tb;
  import kmp_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned ITEM_TARGET = 920;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned TXT_MAX     = 256;
  localparam logic [BYTE_W-1:0] SEPARATOR = 8'h25;

  typedef struct {
    logic                     found;
    logic [MATCH_START_W-1:0] start;
    logic                     overflow;
  } match_result_t;

  class match_tracker;
    match_result_t            pending_matches[$];
    logic [BYTE_W-1:0]        pat_mem[DEF_MAX_PATTERN];
    int unsigned              fail_mem[DEF_MAX_PATTERN];
    int unsigned              pat_len;
    int unsigned              build_k;
    int unsigned              txt_q;
    logic [MATCH_START_W-1:0] txt_pos;
    logic                     ovf;
    int unsigned              failures;

    function new();
      pat_len  = 0;
      build_k  = 0;
      txt_q    = 0;
      txt_pos  = '0;
      ovf      = 1'b0;
      failures = 0;
    endfunction

    function int unsigned fail_of(int unsigned len);
      if (len == 0 || len > DEF_MAX_PATTERN) return 0;
      return fail_mem[len-1];
    endfunction

    function logic [BYTE_W-1:0] pat_of(int unsigned idx);
      return (idx < DEF_MAX_PATTERN) ? pat_mem[idx] : 8'h00;
    endfunction

    function void append_byte(logic [BYTE_W-1:0] c);
      int unsigned k;
      if (pat_len >= DEF_MAX_PATTERN) begin
        ovf = 1'b1;
        return;
      end
      pat_mem[pat_len] = c;
      k = 0;
      if (pat_len != 0) begin
        k = build_k;
        while (k > 0 && pat_of(k) != c) k = fail_of(k);
        if (pat_of(k) == c) k++;
      end
      fail_mem[pat_len] = k;
      build_k = k;
      pat_len++;
    endfunction

    function void add_expected(match_result_t want);
      pending_matches.insert(pending_matches.size(), want);
    endfunction

    function void note_request(kind_e k, logic [BYTE_W-1:0] c);
      match_result_t want;
      int unsigned   q;
      case (k)
        KIND_PAT_FIRST: begin
          pat_len = 0;
          build_k = 0;
          ovf     = 1'b0;
          txt_q   = 0;
          txt_pos = '0;
          append_byte(c);
        end
        KIND_PAT_NEXT: begin
          append_byte(c);
        end
        default: begin
          if (k == KIND_TXT_FIRST) begin
            txt_q   = 0;
            txt_pos = '0;
          end
          want.found = 1'b0;
          want.start = '0;
          if (pat_len > 0) begin
            q = txt_q;
            if (q > pat_len) q = 0;
            if (q == pat_len) q = fail_of(q);
            while (q > 0 && pat_of(q) != c) q = fail_of(q);
            if (pat_of(q) == c) q++;
            txt_q = q;
            if (q == pat_len) begin
              want.found = 1'b1;
              want.start = txt_pos - 32'(pat_len) + 32'd1;
            end
          end else begin
            txt_q = 0;
          end
          txt_pos = txt_pos + 32'd1;
          want.overflow = ovf;
          add_expected(want);
        end
      endcase
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= REPORT_MAX) $display("%s", msg);
    endfunction

    function void check_result(logic found, logic [MATCH_START_W-1:0] start, logic overflow);
      match_result_t want;
      if (pending_matches.size() == 0) begin
        report($sformatf("unexpected result: found=%0b start=%0d overflow=%0b",
                         found, start, overflow));
        return;
      end
      want = pending_matches.pop_front();
      if (found !== want.found || start !== want.start || overflow !== want.overflow)
        report({$sformatf("mismatch: exp found=%0b start=%0d overflow=%0b",
                          want.found, want.start, want.overflow),
                $sformatf(", got found=%0b start=%0d overflow=%0b",
                          found, start, overflow)});
    endfunction

    function int unsigned outstanding();
      return pending_matches.size();
    endfunction

    function void finish_check();
      if (pending_matches.size() != 0)
        report($sformatf("%0d expected results never arrived", pending_matches.size()));
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  kmp_in_if  in_if();
  kmp_out_if out_if();

  match_tracker tracker = new();
  int unsigned  burst_left    = 0;
  int unsigned  items_sent    = 0;
  int unsigned  hold_requests = 0;

  kmp_stream_matcher_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  task automatic send_item(input kind_e k, input logic [BYTE_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.kind       <= k;
    in_if.byte_value <= b;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.note_request(k, b);
    items_sent++;
  endtask

  task automatic drain_wait();
    in_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (tracker.outstanding() > 0);
  endtask

  task automatic run_episode(input int unsigned idx);
    logic [BYTE_W-1:0] alpha[3];
    logic [BYTE_W-1:0] pat_copy[DEF_MAX_PATTERN + 8];
    logic [BYTE_W-1:0] txt[TXT_MAX];
    int unsigned       alpha_n, plen, plen_used, tlen, txt_n, roll, cut, j;
    bit                skip_first;
    kind_e             k;
    if (idx > 1 && $urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(4, 16)) send_item(kind_e'($urandom_range(0, 3)), 8'($urandom));
      return;
    end
    alpha_n = $urandom_range(1, 3);
    foreach (alpha[i]) alpha[i] = 8'($urandom);
    roll = $urandom_range(0, 99);
    if (idx == 0) plen = DEF_MAX_PATTERN;
    else if (idx == 1) plen = DEF_MAX_PATTERN + 3;
    else if (roll < 80) plen = $urandom_range(1, 8);
    else if (roll < 92) plen = $urandom_range(9, 40);
    else if (roll < 96) plen = DEF_MAX_PATTERN;
    else plen = $urandom_range(DEF_MAX_PATTERN + 1, DEF_MAX_PATTERN + 8);
    plen_used = (plen > DEF_MAX_PATTERN) ? DEF_MAX_PATTERN : plen;
    for (j = 0; j < plen; j++) begin
      pat_copy[j] = (j < DEF_MAX_PATTERN) ? alpha[$urandom_range(0, alpha_n - 1)]
                                          : 8'($urandom);
      send_item((j == 0) ? KIND_PAT_FIRST : KIND_PAT_NEXT, pat_copy[j]);
    end
    tlen = $urandom_range(4, 40) + ((plen > 16) ? 2 * plen : 0);
    txt_n = 0;
    while (txt_n < tlen) begin
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        for (j = 0; j < plen_used; j++) begin
          txt[txt_n] = pat_copy[j];
          txt_n++;
        end
      end else if (roll < 30) begin
        cut = $urandom_range(1, plen_used);
        for (j = 0; j < cut; j++) begin
          txt[txt_n] = pat_copy[j];
          txt_n++;
        end
      end else if (roll < 35) begin
        txt[txt_n] = 8'($urandom);
        txt_n++;
      end else begin
        txt[txt_n] = alpha[$urandom_range(0, alpha_n - 1)];
        txt_n++;
      end
    end
    skip_first = ($urandom_range(0, 9) == 0);
    for (j = 0; j < txt_n; j++) begin
      if (j == txt_n / 2 && $urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3))
          send_item(KIND_PAT_NEXT, alpha[$urandom_range(0, alpha_n - 1)]);
      if (j == 0) k = skip_first ? KIND_TXT_NEXT : KIND_TXT_FIRST;
      else k = ($urandom_range(0, 49) == 0) ? KIND_TXT_FIRST : KIND_TXT_NEXT;
      send_item(k, txt[j]);
    end
  endtask

  initial begin : stall_watch
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("kmp_stream_matcher_core_tb: done, errors");
    $finish;
  end

  initial begin : result_sink
    int unsigned mode, mode_left, hold_left, holds_seen, tick;
    mode       = 0;
    mode_left  = 0;
    hold_left  = 0;
    holds_seen = 0;
    tick       = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready)
        tracker.check_result(out_if.match_found, out_if.match_start, out_if.pattern_overflow);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= (tick % 4 == 0);
          default: out_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin : request_source
    int unsigned episode;
    bit          paused;
    episode = 0;
    paused  = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.kind       <= KIND_PAT_FIRST;
    in_if.byte_value <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pattern straight after reset
    send_item(KIND_TXT_NEXT, 8'h00);
    send_item(KIND_TXT_FIRST, 8'hFF);
    send_item(KIND_TXT_NEXT, 8'h41);
    send_item(KIND_PAT_FIRST, 8'h00);
    send_item(KIND_PAT_NEXT, 8'hFF);
    send_item(KIND_PAT_NEXT, 8'h00);
    // text with no first-text request, overlapping occurrences
    send_item(KIND_TXT_NEXT, 8'h00);
    send_item(KIND_TXT_NEXT, 8'hFF);
    send_item(KIND_TXT_NEXT, 8'h00);
    send_item(KIND_TXT_NEXT, 8'hFF);
    send_item(KIND_TXT_NEXT, 8'h00);
    // pattern grows in the middle of a text
    send_item(KIND_TXT_FIRST, 8'h00);
    send_item(KIND_TXT_NEXT, 8'hFF);
    send_item(KIND_PAT_NEXT, 8'hFF);
    send_item(KIND_TXT_NEXT, 8'h00);
    send_item(KIND_TXT_NEXT, 8'hFF);
    send_item(KIND_PAT_FIRST, SEPARATOR);
    send_item(KIND_TXT_FIRST, SEPARATOR);
    send_item(KIND_TXT_NEXT, SEPARATOR);
    send_item(KIND_TXT_NEXT, SEPARATOR);
    drain_wait();

    while (items_sent < ITEM_TARGET) begin
      if (hold_requests == 0 && items_sent >= 250) hold_requests++;
      if (hold_requests == 1 && items_sent >= 700) hold_requests++;
      if (!paused && items_sent >= 550) begin
        drain_wait();
        paused = 1'b1;
      end
      run_episode(episode);
      episode++;
    end

    drain_wait();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    tracker.finish_check();
    if (tracker.failures == 0) begin
      $display("kmp_stream_matcher_core_tb: done, clean");
    end else begin
      $display("kmp_stream_matcher_core_tb: done, errors");
    end
    $finish;
  end

endmodule
